### rtl/core/sawt_pkg.sv
// Shared types and constants of the sequence acknowledgement window tracker.
package sawt_pkg;

	localparam int SEQ_W       = 32;
	localparam int ACK_WIN_W   = 32;
	localparam int WINDOW_BITS = 32;
	localparam int WIN_SHW     = $clog2(WINDOW_BITS + 1);

	localparam logic [SEQ_W-1:0]       HALF_RANGE = 32'h8000_0000;
	localparam logic [SEQ_W-1:0]       WIN_SPAN   = SEQ_W'(WINDOW_BITS);
	localparam logic [WIN_SHW-1:0]     WIN_COUNT  = WIN_SHW'(WINDOW_BITS);
	localparam logic [WINDOW_BITS-1:0] WIN_ONE    = WINDOW_BITS'(1);

	typedef enum logic [1:0] {
		VERDICT_NEWER        = 2'd0,
		VERDICT_OUT_OF_ORDER = 2'd1,
		VERDICT_DUPLICATE    = 2'd2,
		VERDICT_DROPPED      = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [SEQ_W-1:0]       newest;
		logic [WINDOW_BITS-1:0] window;
	} sawt_state_t;

endpackage

### rtl/core/sawt_if.sv
// Valid/ready channels for received sequence numbers and tracker results.
interface sawt_rx_if;
	logic        valid;
	logic        ready;
	logic [31:0] rx_sequence;

	modport source (output valid, output rx_sequence, input ready);
	modport sink   (input valid, input rx_sequence, output ready);
endinterface

interface sawt_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [31:0] ack_sequence;
	logic [31:0] ack_window;

	modport source (output valid, output verdict, output ack_sequence, output ack_window,
		input ready);
	modport sink   (input valid, input verdict, input ack_sequence, input ack_window,
		output ready);
endinterface

### rtl/core/sawt_classify.sv
// Combinational comparison of one sequence number against the window and next-state logic.
module sawt_classify
	import sawt_pkg::*;
(
	input  logic [SEQ_W-1:0] rx_sequence,
	input  sawt_state_t      cur,
	input  logic             drop_out_of_order,
	output verdict_t         verdict,
	output sawt_state_t      nxt
);

	logic [SEQ_W-1:0]       fwd;
	logic [SEQ_W-1:0]       back;
	logic                   newer;
	logic                   back_in_win;
	logic [WINDOW_BITS-1:0] shifted;
	logic [WINDOW_BITS-1:0] fwd_mark;
	logic [WINDOW_BITS-1:0] back_mark;

	always_comb begin
		fwd  = rx_sequence - cur.newest;
		back = cur.newest - rx_sequence;

		// exactly half range counts as newer only when the new number is numerically smaller
		newer = (fwd != '0) &&
			(!fwd[SEQ_W-1] || ((fwd == HALF_RANGE) && (rx_sequence < cur.newest)));
		back_in_win = (back != '0) && (back <= WIN_SPAN);

		shifted   = (fwd < WIN_SPAN) ? (cur.window >> fwd[WIN_SHW-1:0]) : '0;
		fwd_mark  = (fwd <= WIN_SPAN) ? (WIN_ONE << (WIN_COUNT - fwd[WIN_SHW-1:0])) : '0;
		back_mark = back_in_win ? (WIN_ONE << (WIN_COUNT - back[WIN_SHW-1:0])) : '0;

		nxt = cur;
		if (fwd == '0) begin
			verdict = VERDICT_DUPLICATE;
		end else if (newer) begin
			verdict    = VERDICT_NEWER;
			nxt.newest = rx_sequence;
			nxt.window = shifted | fwd_mark;
		end else begin
			verdict = drop_out_of_order ? VERDICT_DROPPED : VERDICT_OUT_OF_ORDER;
			// beyond the window: accept unchecked, leave the marks alone
			if (back_in_win) begin
				if ((cur.window & back_mark) != '0) begin
					verdict = VERDICT_DUPLICATE;
				end else begin
					nxt.window = cur.window | back_mark;
				end
			end
		end
	end

endmodule

### rtl/core/sequence_ack_window_tracker_unit.sv
// Top level of the sequence acknowledgement window tracker.
// Takes one 32-bit sequence number per transfer on rx and returns one result per number on
// res: the verdict (newer, out of order, duplicate, dropped), the newest sequence seen and
// the 32 receive marks below it, MSB for newest minus one. A new number is taken every
// cycle while res is not stalled; each number waits in the input register and its result
// in the result register. The input register's number is compared, the window shifted or
// marked and the newest/window state rewritten for the next number as its result is
// registered. drop_out_of_order is written with cfg_wr_en and is to be changed only while
// no numbers are in flight. Reset clears the newest sequence and the window to zero.
module sequence_ack_window_tracker_unit
	import sawt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	sawt_rx_if.sink      rx,
	sawt_res_if.source   res
);

	logic                 valid_s1;
	logic [SEQ_W-1:0]     seq_s1;
	logic                 advance;
	logic                 drop_q;
	sawt_state_t          state_q;
	sawt_state_t          state_nxt;
	verdict_t             verdict_nxt;
	logic                 res_valid_q;
	verdict_t             verdict_q;
	logic [SEQ_W-1:0]     ack_sequence_q;
	logic [ACK_WIN_W-1:0] ack_window_q;
	logic [ACK_WIN_W-1:0] ack_window_nxt;

	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	sawt_classify u_classify (
		.rx_sequence       (seq_s1),
		.cur               (state_q),
		.drop_out_of_order (drop_q),
		.verdict           (verdict_nxt),
		.nxt               (state_nxt)
	);

	generate
		if (WINDOW_BITS >= ACK_WIN_W) begin : g_win_wide
			assign ack_window_nxt = state_nxt.window[WINDOW_BITS-1 -: ACK_WIN_W];
		end else begin : g_win_narrow
			assign ack_window_nxt = {state_nxt.window, {(ACK_WIN_W-WINDOW_BITS){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			drop_q      <= 1'b0;
			state_q     <= '0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				drop_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			seq_s1 <= rx.rx_sequence;
		end
		if (advance) begin
			verdict_q      <= verdict_nxt;
			ack_sequence_q <= state_nxt.newest;
			ack_window_q   <= ack_window_nxt;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.verdict      = verdict_q;
	assign res.ack_sequence = ack_sequence_q;
	assign res.ack_window   = ack_window_q;

endmodule

### rtl/core/sawt_checker.sv
// Port-level assertions for the tracker top level, with the bind that attaches them.
module sawt_checker
	import sawt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_verdict,
	input logic [31:0] res_ack_sequence,
	input logic [31:0] res_ack_window
);

	logic        res_xfer;
	logic [31:0] last_seq_q;

	assign res_xfer = res_valid && res_ready;

	// track the newest sequence reported so far; reset state is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q <= '0;
		end else if (res_xfer) begin
			last_seq_q <= res_ack_sequence;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_verdict) &&
			$stable(res_ack_sequence) && $stable(res_ack_window))
		else $error("result changed while stalled");

	a_old_keeps_newest: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && (res_verdict != VERDICT_NEWER) |-> res_ack_sequence == last_seq_q)
		else $error("non-newer verdict moved the newest sequence");

	a_newer_moves: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && (res_verdict == VERDICT_NEWER) |-> res_ack_sequence != last_seq_q)
		else $error("newer verdict without a new newest sequence");

	a_step_marks: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && (res_verdict == VERDICT_NEWER) && (res_ack_sequence == last_seq_q + 32'd1)
			|-> res_ack_window[31])
		else $error("previous newest not marked after a step of one");

endmodule

bind sequence_ack_window_tracker_unit sawt_checker u_sawt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_verdict      (res.verdict),
	.res_ack_sequence (res.ack_sequence),
	.res_ack_window   (res.ack_window)
);
